FILE: hdl/fat_short_name_directory_search_macros.svh
// Assertion macros for the FAT short-name directory search block.
// Used by the port checker; needs clk and rst in the including scope.
`ifndef FAT_SHORT_NAME_DIRECTORY_SEARCH_MACROS_SVH
`define FAT_SHORT_NAME_DIRECTORY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FSNDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FSNDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fsnds_pkg.sv
// Shared types and constants for the FAT short-name directory search.
// No dependencies.
package fsnds_pkg;

  localparam int NameBytes  = 11;
  localparam int IndexBits  = 12;
  localparam int PosBits    = $clog2(NameBytes + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [7:0]         ChrSpace     = 8'h20;
  localparam logic [7:0]         ChrDot       = 8'h2E;
  localparam logic [7:0]         ChrLowA      = 8'h61;
  localparam logic [7:0]         ChrLowZ      = 8'h7A;
  localparam logic [7:0]         CaseOffset   = 8'h20;
  localparam logic [7:0]         TypeSkipMask = 8'h18;
  localparam logic [3:0]         RejectCount  = 4'd13;
  localparam logic [3:0]         ConsumedMax  = 4'd15;
  localparam logic [PosBits-1:0] ExtPos       = PosBits'(8);
  localparam logic [PosBits-1:0] PosEnd       = PosBits'(NameBytes);
  localparam logic [IndexBits-1:0] MaxEntriesReset = IndexBits'(224);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_ENTRY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_REJECTED  = 2'd3
  } status_t;

  typedef logic [NameBytes-1:0][7:0] name_t;

  // Classified word handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;          // upper-cased name character
    logic       ch_zero;
    logic       ch_dot;
    name_t      entry_name;  // byte 0 in lowest bits
    logic       entry_skip;  // volume or directory entry
  } word_t;

endpackage

FILE: hdl/fat_short_name_directory_search.sv
// FAT 8.3 short-name directory search, top level.
// Depends on fsnds_pkg, fsnds_front, fsnds_queue, fsnds_back.
//
// Input channel (in_valid / in_stall): one word per command. A start word
// clears the search, name-character words build the 8.3 target name up to
// a zero terminator, entry words then carry directory entries in order.
// Output channel (out_valid / out_stall): exactly one result word per
// input word, in order: status and, when found, the entry index.
// cfg_write / cfg_data load max_entries (reset value 224); the user must
// write it only while idle, the block does not enforce this. An accepted
// word goes into the queue; its result is registered when it is popped.
// Throughput: one word per cycle unless the receiver stalls; the back end
// folds a name character or compares 11 entry name bytes combinationally.
// Reset (rst, synchronous) empties the queue and the result register and
// clears the search state. While the receiver stalls, the result holds and
// the queue absorbs up to two more words; in_stall rises when it is full.
module fat_short_name_directory_search import fsnds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IndexBits-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [7:0]           name_char,
  input  logic [63:0]          entry_name_head,
  input  logic [23:0]          entry_name_tail,
  input  logic [7:0]           entry_type,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [IndexBits-1:0] entry_index
);

  logic  q_full;
  logic  push;
  word_t push_word;
  logic  pop;
  logic  head_valid;
  word_t head_word;

  fsnds_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .name_char       (name_char),
    .entry_name_head (entry_name_head),
    .entry_name_tail (entry_name_tail),
    .entry_type      (entry_type),
    .q_full          (q_full),
    .push            (push),
    .word            (push_word)
  );

  fsnds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  fsnds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .head_valid  (head_valid),
    .head_word   (head_word),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_index (entry_index)
  );

endmodule

FILE: hdl/fsnds_front.sv
// Front end: accepts input words and classifies them for the back end.
// Depends on fsnds_pkg.
module fsnds_front import fsnds_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  name_char,
  input  logic [63:0] entry_name_head,
  input  logic [23:0] entry_name_tail,
  input  logic [7:0]  entry_type,
  input  logic        q_full,
  output logic        push,
  output word_t       word
);

  // Handshake toward the queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Decode and fold the name character
  always_comb begin
    word.cmd     = cmd_t'(command);
    word.ch_zero = (name_char == 8'h00);
    word.ch_dot  = (name_char == ChrDot);
    if (name_char >= ChrLowA && name_char <= ChrLowZ) begin
      word.ch = name_char - CaseOffset;
    end else begin
      word.ch = name_char;
    end
    word.entry_name = {entry_name_tail, entry_name_head};
    word.entry_skip = ((entry_type & TypeSkipMask) != 8'h00);
  end

endmodule

FILE: hdl/fsnds_queue.sv
// Short FIFO of classified words between front and back.
// Depends on fsnds_pkg.
module fsnds_queue import fsnds_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output word_t head_word
);

  word_t                slots [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr;
  logic [QPtrBits-1:0]  rd_ptr;
  logic [QCntBits-1:0]  count;

  assign full       = (count == QCntBits'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_word  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

endmodule

FILE: hdl/fsnds_back.sv
// Back end: search state, name folding, entry compare and result register.
// Depends on fsnds_pkg.
module fsnds_back import fsnds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IndexBits-1:0] cfg_data,
  input  logic                 head_valid,
  input  word_t                head_word,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [IndexBits-1:0] entry_index
);

  logic [IndexBits-1:0] max_entries;
  name_t                target_name, target_name_next;
  logic [PosBits-1:0]   name_position, name_position_next;
  logic [3:0]           chars_consumed, chars_consumed_next;
  logic                 name_complete, name_complete_next;
  logic                 name_rejected, name_rejected_next;
  logic [IndexBits-1:0] entries_seen, entries_seen_next;
  logic                 search_finished, search_finished_next;

  status_t              res_status;
  logic [IndexBits-1:0] res_index;
  logic [IndexBits-1:0] seen_inc;
  logic                 name_match;

  // Take the head word whenever the result register is free or draining
  assign pop = head_valid && (!out_valid || !out_stall);

  assign seen_inc   = entries_seen + 1'b1;
  assign name_match = (head_word.entry_name == target_name);

  // Next search state and result for the head word
  always_comb begin
    target_name_next     = target_name;
    name_position_next   = name_position;
    chars_consumed_next  = chars_consumed;
    name_complete_next   = name_complete;
    name_rejected_next   = name_rejected;
    entries_seen_next    = entries_seen;
    search_finished_next = search_finished;
    res_status           = ST_PENDING;
    res_index            = '0;
    unique case (head_word.cmd)
      CMD_START: begin
        target_name_next     = {NameBytes{ChrSpace}};
        name_position_next   = '0;
        chars_consumed_next  = '0;
        name_complete_next   = 1'b0;
        name_rejected_next   = 1'b0;
        entries_seen_next    = '0;
        search_finished_next = 1'b0;
      end
      CMD_CHAR: begin
        if (!name_complete) begin
          if (head_word.ch_zero) begin
            name_complete_next = 1'b1;
            if (chars_consumed == RejectCount) begin
              name_rejected_next   = 1'b1;
              search_finished_next = 1'b1;
              res_status           = ST_REJECTED;
            end else if (max_entries == '0) begin
              search_finished_next = 1'b1;
              res_status           = ST_NOT_FOUND;
            end
          end else if (name_position < PosEnd) begin
            // dot jumps to the extension while in the base name or at the extension start
            if (head_word.ch_dot && name_position <= ExtPos) begin
              name_position_next = ExtPos;
            end else begin
              target_name_next[name_position] = head_word.ch;
              name_position_next              = name_position + 1'b1;
            end
            if (chars_consumed != ConsumedMax) begin
              chars_consumed_next = chars_consumed + 1'b1;
            end
          end
        end
      end
      CMD_ENTRY: begin
        if (name_complete) begin
          if (name_rejected) begin
            res_status = ST_REJECTED;
          end else if (!search_finished) begin
            if (entries_seen >= max_entries) begin
              search_finished_next = 1'b1;
              res_status           = ST_NOT_FOUND;
            end else if (head_word.entry_name[0] == 8'h00) begin
              // end-of-directory marker
              search_finished_next = 1'b1;
              res_status           = ST_NOT_FOUND;
            end else if (!head_word.entry_skip && name_match) begin
              search_finished_next = 1'b1;
              res_status           = ST_FOUND;
              res_index            = entries_seen;
            end else begin
              entries_seen_next = seen_inc;
              if (seen_inc >= max_entries) begin
                search_finished_next = 1'b1;
                res_status           = ST_NOT_FOUND;
              end
            end
          end
        end
      end
      default: begin
        // unused command: no effect
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MaxEntriesReset;
    end else if (cfg_write) begin
      max_entries <= cfg_data;
    end
  end

  // Search state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_name     <= {NameBytes{ChrSpace}};
      name_position   <= '0;
      chars_consumed  <= '0;
      name_complete   <= 1'b0;
      name_rejected   <= 1'b0;
      entries_seen    <= '0;
      search_finished <= 1'b0;
    end else if (pop) begin
      target_name     <= target_name_next;
      name_position   <= name_position_next;
      chars_consumed  <= chars_consumed_next;
      name_complete   <= name_complete_next;
      name_rejected   <= name_rejected_next;
      entries_seen    <= entries_seen_next;
      search_finished <= search_finished_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status      <= res_status;
      entry_index <= res_index;
    end
  end

endmodule

FILE: hdl/fsnds_checker.sv
// Port-level checker for the FAT short-name directory search, bound to the top.
// Depends on fsnds_pkg and fat_short_name_directory_search_macros.svh.
`include "fat_short_name_directory_search_macros.svh"

module fsnds_checker import fsnds_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           status,
  input logic [IndexBits-1:0] entry_index
);

  // stalled result word holds
  `FSNDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_index), "stalled result word changed")

  // only a found result carries an index
  `FSNDS_ASSERT_NOW(a_index_zero, out_valid && status != ST_FOUND, entry_index == '0, "index set on a result that is not found")

  // with the result register empty the queue is not full, so input is open
  `FSNDS_ASSERT_NOW(a_open_when_empty, !out_valid, !in_stall, "input stalled while output is empty")

endmodule

bind fat_short_name_directory_search fsnds_checker u_fsnds_checker (.*);
